@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, reset disables.
`define ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

@@ src/mtsp_pkg.sv @@
// ----------------------------------------------------------------------------
// mtsp_pkg
// Constants and types shared by the touch point unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mtsp_pkg;
  localparam int SLOTS = 10;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FRACTION_BITS = 16;
  localparam int NORM_W = FRACTION_BITS + 1;
  localparam int QUO_W = FRACTION_BITS + 1;

  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;
  localparam logic [4:0] EV_ABS = 5'd3;
  localparam logic [9:0] ABS_X = 10'h000;
  localparam logic [9:0] ABS_Y = 10'h001;
  localparam logic [9:0] CODE_SLOT_SEL = 10'h02f;
  localparam logic [9:0] CODE_MT_X = 10'h035;
  localparam logic [9:0] CODE_MT_Y = 10'h036;
  localparam logic [9:0] CODE_TRACK_ID = 10'h039;
  localparam logic [9:0] CODE_TOUCH_BTN = 10'h14a;
  localparam logic [9:0] CODE_VOL_DOWN = 10'd114;
  localparam logic [9:0] CODE_VOL_UP = 10'd115;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MAX_X = 3'd1;
  localparam logic [2:0] REG_MIN_Y = 3'd2;
  localparam logic [2:0] REG_MAX_Y = 3'd3;
  localparam logic [2:0] REG_SCR_W = 3'd4;
  localparam logic [2:0] REG_SCR_H = 3'd5;
  localparam logic [2:0] REG_MAP = 3'd6;
  localparam logic [2:0] REG_MT = 3'd7;

  typedef struct packed {
    logic start;
    logic [32:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ src/mtsp_div.sv @@
// ----------------------------------------------------------------------------
// mtsp_div
// Shared restoring divider: floor(num * 2^FRACTION_BITS / den), num < den.
// ----------------------------------------------------------------------------
`default_nettype none
module mtsp_div import mtsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_req_t req,
  output div_rsp_t rsp
);
  localparam int CNT_W = $clog2(QUO_W + 1);
  logic [33:0] rem;
  logic [32:0] den;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic [33:0] sh;
  logic [33:0] diff;

  always_comb begin
    sh = {rem[32:0], 1'b0};
    diff = sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !req.start && busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        rem <= {1'b0, req.num};
        den <= req.den;
        quo <= '0;
        cnt <= CNT_W'(FRACTION_BITS);
      end else if (busy) begin
        if (!diff[33]) begin
          rem <= diff;
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= sh;
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        if (cnt == '0) busy <= 1'b0;
        else cnt <= cnt - CNT_W'(1);
      end
    end
  end
  assign rsp.done = done;
  assign rsp.quo = quo;
endmodule
`default_nettype wire

@@ src/multitouch_event_to_screen_point_unit.sv @@
// ----------------------------------------------------------------------------
// multitouch_event_to_screen_point_unit
// Tracks finger slots from input events and reports a screen point on sync.
// ----------------------------------------------------------------------------
// Use: input events enter on s_axis (tdata = type, code, value). Axis and key
// events update state in the cycle after the beat, and the block takes no new
// event until that update is done; they give no result. A sync event (type 0,
// code 0) starts a report: a scan over SLOTS slots one per cycle, up to two
// normalizing divides on one shared divider, and two scaling multiplies on one
// shared multiplier. m_axis_tvalid rises when the report is done; a coordinate
// that clamps skips its divide, and no divide or multiply runs when no finger
// is down or a panel range is not positive. s_axis_tready is low while an
// event is in work and while the result waits; a stalled receiver holds the
// block. Configuration writes (cfg_we, cfg_index, cfg_data) must go in only
// while idle; the block itself does not enforce this. Reset clears all finger
// state, the report state and the volume keys and loads the register
// defaults; it is synchronous.
`default_nettype none
`include "assert_macros.svh"
module multitouch_event_to_screen_point_unit import mtsp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // event_type, event_code, event_value, pad
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [87:0] m_axis_tdata,  // touch_down, screen_x, screen_y, norm_x,
                                     // norm_y, changed, exit_chord, pad
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EXEC = 4'd1;
  localparam logic [3:0] ST_SCAN = 4'd2;
  localparam logic [3:0] ST_PICK = 4'd3;
  localparam logic [3:0] ST_DIVX = 4'd4;
  localparam logic [3:0] ST_WX = 4'd5;
  localparam logic [3:0] ST_DIVY = 4'd6;
  localparam logic [3:0] ST_WY = 4'd7;
  localparam logic [3:0] ST_MAP = 4'd8;
  localparam logic [3:0] ST_MULX = 4'd9;
  localparam logic [3:0] ST_MULY = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;
  localparam logic [3:0] ST_OUT = 4'd12;
  localparam logic [NORM_W-1:0] ONE = NORM_W'(1) << FRACTION_BITS;

  logic [3:0] state;
  logic signed [31:0] min_x, max_x, min_y, max_y;
  logic [15:0] scr_w, scr_h;
  logic [4:0] map_mode;
  logic mt_mode;

  logic [SLOTS-1:0] fdown;
  logic [31:0] forder [SLOTS];
  logic signed [31:0] fx [SLOTS];
  logic signed [31:0] fy [SLOTS];
  logic [31:0] press_cnt;
  logic [SLOT_W-1:0] cur_slot;
  logic vol_up, vol_dn;

  logic rep_down;
  logic [23:0] rep_x, rep_y;
  logic [NORM_W-1:0] rep_nx, rep_ny;
  logic chg;

  logic [4:0] ev_type;
  logic [9:0] ev_code;
  logic signed [31:0] ev_val;

  logic [SLOT_W-1:0] idx;
  logic found;
  logic [SLOT_W-1:0] best;
  logic [31:0] best_order;
  logic signed [31:0] raw_x, raw_y;
  logic [NORM_W-1:0] nx, ny, mx, my;
  logic [23:0] sx;
  logic [32:0] mul_q;

  div_req_t dreq;
  div_rsp_t drsp;

  mtsp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [32:0] rng_x, rng_y, dx, dy;
  assign rng_x = 33'(max_x) - 33'(min_x);
  assign rng_y = 33'(max_y) - 33'(min_y);
  assign dx = 33'(raw_x) - 33'(min_x);
  assign dy = 33'(raw_y) - 33'(min_y);

  logic [SLOT_W-1:0] eslot;
  logic signed [31:0] slot_clamp;
  always_comb begin
    eslot = mt_mode ? cur_slot : '0;
    if (ev_val < 0) slot_clamp = 0;
    else if (ev_val >= SLOTS) slot_clamp = SLOTS - 1;
    else slot_clamp = ev_val;
  end

  // shared multiplier
  logic [NORM_W-1:0] mul_a;
  logic [15:0] mul_b;
  logic [NORM_W+15:0] mul_p;
  always_comb begin
    mul_a = (state == ST_MULX) ? mx : my;
    mul_b = (state == ST_MULX) ? scr_w : scr_h;
    if (mul_b == '0) mul_b = 16'd1;
    mul_p = {16'd0, mul_a} * {{NORM_W{1'b0}}, mul_b};
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = '0;
    if (state == ST_DIVX) begin
      dreq.start = (dx > 0) && (dx < rng_x);
      dreq.num = dx;
      dreq.den = rng_x;
    end else if (state == ST_DIVY) begin
      dreq.start = (dy > 0) && (dy < rng_y);
      dreq.num = dy;
      dreq.den = rng_y;
    end
  end

  logic [NORM_W-1:0] ax, ay, bx, by;
  always_comb begin
    ax = map_mode[0] ? ny : nx;
    ay = map_mode[0] ? nx : ny;
    if (map_mode[1]) ax = ONE - ax;
    if (map_mode[2]) ay = ONE - ay;
    unique case (map_mode[4:3])
      2'd1: begin bx = ay; by = ONE - ax; end
      2'd2: begin bx = ONE - ax; by = ONE - ay; end
      2'd3: begin bx = ONE - ay; by = ax; end
      default: begin bx = ax; by = ay; end
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {3'b000, vol_up & vol_dn, chg, rep_ny, rep_nx, rep_y, rep_x,
                         rep_down};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0; max_x <= '0; min_y <= '0; max_y <= '0;
      scr_w <= 16'd1; scr_h <= 16'd1; map_mode <= '0; mt_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: min_x <= cfg_data;
        REG_MAX_X: max_x <= cfg_data;
        REG_MIN_Y: min_y <= cfg_data;
        REG_MAX_Y: max_y <= cfg_data;
        REG_SCR_W: scr_w <= cfg_data[15:0];
        REG_SCR_H: scr_h <= cfg_data[15:0];
        REG_MAP: map_mode <= cfg_data[4:0];
        REG_MT: mt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fdown <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        forder[i] <= '0; fx[i] <= '0; fy[i] <= '0;
      end
      press_cnt <= '0; cur_slot <= '0; vol_up <= 1'b0; vol_dn <= 1'b0;
      rep_down <= 1'b0; rep_x <= '0; rep_y <= '0; rep_nx <= '0; rep_ny <= '0;
      chg <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          ev_type <= s_axis_tdata[4:0];
          ev_code <= s_axis_tdata[14:5];
          ev_val <= s_axis_tdata[46:15];
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= (ev_type == EV_SYN && ev_code == '0) ? ST_SCAN : ST_IDLE;
          if (ev_type == EV_ABS) begin
            if (ev_code == CODE_SLOT_SEL) cur_slot <= SLOT_W'(slot_clamp);
            else if (ev_code == CODE_TRACK_ID) begin
              if (ev_val == -32'sd1) fdown[eslot] <= 1'b0;
              else begin
                fdown[eslot] <= 1'b1;
                forder[eslot] <= press_cnt + 32'd1;
                press_cnt <= press_cnt + 32'd1;
              end
            end else if (ev_code == CODE_MT_X || (!mt_mode && ev_code == ABS_X))
              fx[eslot] <= ev_val;
            else if (ev_code == CODE_MT_Y || (!mt_mode && ev_code == ABS_Y))
              fy[eslot] <= ev_val;
          end else if (ev_type == EV_KEY) begin
            if (ev_code == CODE_TOUCH_BTN && !mt_mode) begin
              fdown[0] <= (ev_val != 0);
              if (ev_val != 0) begin
                forder[0] <= press_cnt + 32'd1;
                press_cnt <= press_cnt + 32'd1;
              end
            end else if (ev_code == CODE_VOL_UP) vol_up <= (ev_val != 0);
            else if (ev_code == CODE_VOL_DOWN) vol_dn <= (ev_val != 0);
          end else if (ev_type == EV_SYN && ev_code == '0) begin
            idx <= '0; found <= 1'b0; best <= '0; best_order <= '0;
          end
        end
        ST_SCAN: begin
          if (fdown[idx] && (!found || forder[idx] > best_order)) begin
            found <= 1'b1; best <= idx; best_order <= forder[idx];
          end
          if (idx == SLOT_W'(SLOTS - 1)) state <= ST_PICK;
          else idx <= idx + SLOT_W'(1);
        end
        ST_PICK: begin
          raw_x <= fx[best]; raw_y <= fy[best];
          if (!found) begin
            chg <= rep_down; rep_down <= 1'b0; state <= ST_OUT;
          end else if (rng_x <= 0 || rng_y <= 0) begin
            chg <= 1'b0; state <= ST_OUT;
          end else state <= ST_DIVX;
        end
        ST_DIVX: begin
          nx <= (dx <= 0) ? '0 : ONE;
          state <= ((dx > 0) && (dx < rng_x)) ? ST_WX : ST_DIVY;
        end
        ST_WX: if (drsp.done) begin nx <= drsp.quo; state <= ST_DIVY; end
        ST_DIVY: begin
          ny <= (dy <= 0) ? '0 : ONE;
          state <= ((dy > 0) && (dy < rng_y)) ? ST_WY : ST_MAP;
        end
        ST_WY: if (drsp.done) begin ny <= drsp.quo; state <= ST_MAP; end
        ST_MAP: begin mx <= bx; my <= by; state <= ST_MULX; end
        ST_MULX: begin
          mul_q <= 33'(mul_p >> (FRACTION_BITS - 8));
          state <= ST_MULY;
        end
        ST_MULY: begin
          sx <= mul_q[23:0];
          mul_q <= 33'(mul_p >> (FRACTION_BITS - 8));
          state <= ST_DONE;
        end
        ST_DONE: begin
          chg <= (sx != rep_x) || (mul_q[23:0] != rep_y) || !rep_down;
          rep_x <= sx; rep_y <= mul_q[23:0]; rep_down <= 1'b1;
          rep_nx <= nx; rep_ny <= ny;
          state <= ST_OUT;
        end
        ST_OUT: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, s_axis_tready, !m_axis_tvalid)
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_norm_range, clk, rst, m_axis_tvalid, rep_nx <= ONE && rep_ny <= ONE)
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for multitouch_event_to_screen_point_unit
// Drives input events into the touch point unit and predicts every report.
// A scoreboard keeps its own copy of the slot, volume key and report state,
// computes each expected report on a sync beat and checks results field by
// field. Configuration goes through several panel ranges, screen sizes,
// mapping modes and both panel modes, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class touch_scoreboard;
  longint lo_x, hi_x, lo_y, hi_y;
  longint scr_w, scr_h;
  bit [4:0] map;
  bit mt;
  bit down[mtsp_pkg::SLOTS];
  bit [31:0] order[mtsp_pkg::SLOTS];
  longint raw_x[mtsp_pkg::SLOTS];
  longint raw_y[mtsp_pkg::SLOTS];
  bit [31:0] presses;
  int slot;
  bit rep_down;
  longint rep_x, rep_y, rep_nx, rep_ny;
  bit vol_up, vol_dn;
  bit [87:0] pending[$];
  int errors, reports, changes, chords, events;

  function new();
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    scr_w = 1; scr_h = 1; map = 0; mt = 1;
    for (int i = 0; i < mtsp_pkg::SLOTS; i++) begin
      down[i] = 0; order[i] = 0; raw_x[i] = 0; raw_y[i] = 0;
    end
    presses = 0; slot = 0; rep_down = 0;
    rep_x = 0; rep_y = 0; rep_nx = 0; rep_ny = 0;
    vol_up = 0; vol_dn = 0;
    errors = 0; reports = 0; changes = 0; chords = 0; events = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      mtsp_pkg::REG_MIN_X: lo_x = longint'(signed'(val));
      mtsp_pkg::REG_MAX_X: hi_x = longint'(signed'(val));
      mtsp_pkg::REG_MIN_Y: lo_y = longint'(signed'(val));
      mtsp_pkg::REG_MAX_Y: hi_y = longint'(signed'(val));
      mtsp_pkg::REG_SCR_W: scr_w = val[15:0];
      mtsp_pkg::REG_SCR_H: scr_h = val[15:0];
      mtsp_pkg::REG_MAP: map = val[4:0];
      mtsp_pkg::REG_MT: mt = val[0];
      default: ;
    endcase
  endfunction

  function longint frac_of(longint raw, longint lo, longint range);
    longint d;
    d = raw - lo;
    if (d <= 0) return 0;
    if (d >= range) return longint'(1) << mtsp_pkg::FRACTION_BITS;
    return (d << mtsp_pkg::FRACTION_BITS) / range;
  endfunction

  function longint pixels(longint v, longint size);
    return (v * (size == 0 ? 1 : size)) >> (mtsp_pkg::FRACTION_BITS - 8);
  endfunction

  function bit update_report();
    int best;
    longint one, rx, ry, nx, ny, x, y, t, sx, sy;
    bit chg;
    one = longint'(1) << mtsp_pkg::FRACTION_BITS;
    best = -1;
    for (int i = 0; i < mtsp_pkg::SLOTS; i++)
      if (down[i] && (best < 0 || order[i] > order[best])) best = i;
    if (best < 0) begin
      if (rep_down) begin
        rep_down = 0;
        return 1;
      end
      return 0;
    end
    rx = hi_x - lo_x;
    ry = hi_y - lo_y;
    if (rx <= 0 || ry <= 0) return 0;
    nx = frac_of(raw_x[best], lo_x, rx);
    ny = frac_of(raw_y[best], lo_y, ry);
    x = nx; y = ny;
    if (map[0]) begin t = x; x = y; y = t; end
    if (map[1]) x = one - x;
    if (map[2]) y = one - y;
    case (map[4:3])
      2'd1: begin t = x; x = y; y = one - t; end
      2'd2: begin x = one - x; y = one - y; end
      2'd3: begin t = x; x = one - y; y = t; end
      default: ;
    endcase
    sx = pixels(x, scr_w);
    sy = pixels(y, scr_h);
    chg = (sx != rep_x) || (sy != rep_y) || !rep_down;
    rep_x = sx; rep_y = sy; rep_down = 1; rep_nx = nx; rep_ny = ny;
    return chg;
  endfunction

  function void note_event(logic [4:0] kind, logic [9:0] code, logic [31:0] value);
    int s;
    longint v;
    bit chg;
    bit [23:0] ex, ey;
    bit [16:0] enx, eny;
    v = longint'(signed'(value));
    events++;
    if (kind == mtsp_pkg::EV_ABS) begin
      if (code == mtsp_pkg::CODE_SLOT_SEL) begin
        if (v < 0) v = 0;
        if (v >= mtsp_pkg::SLOTS) v = mtsp_pkg::SLOTS - 1;
        slot = int'(v);
        return;
      end
      s = mt ? slot : 0;
      if (code == mtsp_pkg::CODE_TRACK_ID) begin
        if (v == -1) down[s] = 0;
        else begin
          down[s] = 1;
          presses++;
          order[s] = presses;
        end
      end else if (code == mtsp_pkg::CODE_MT_X || (!mt && code == mtsp_pkg::ABS_X))
        raw_x[s] = v;
      else if (code == mtsp_pkg::CODE_MT_Y || (!mt && code == mtsp_pkg::ABS_Y))
        raw_y[s] = v;
    end else if (kind == mtsp_pkg::EV_KEY) begin
      if (code == mtsp_pkg::CODE_TOUCH_BTN && !mt) begin
        down[0] = (v != 0);
        if (v != 0) begin
          presses++;
          order[0] = presses;
        end
      end else if (code == mtsp_pkg::CODE_VOL_UP) vol_up = (v != 0);
      else if (code == mtsp_pkg::CODE_VOL_DOWN) vol_dn = (v != 0);
    end else if (kind == mtsp_pkg::EV_SYN && code == 10'd0) begin
      chg = update_report();
      ex = rep_x[23:0]; ey = rep_y[23:0]; enx = rep_nx[16:0]; eny = rep_ny[16:0];
      pending.insert(pending.size(),
                     {3'b000, vol_up && vol_dn, chg, eny, enx, ey, ex, rep_down});
    end
  endfunction

  function void field_check(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  function void check_result(logic [87:0] got);
    bit [87:0] e;
    if (pending.size() == 0) begin
      $error("unexpected result beat %h", got);
      errors++;
      return;
    end
    e = pending.pop_front();
    reports++;
    changes += e[83];
    chords += e[84];
    field_check("touch_down", e[0], got[0]);
    field_check("screen_x", e[24:1], got[24:1]);
    field_check("screen_y", e[48:25], got[48:25]);
    field_check("norm_x", e[65:49], got[65:49]);
    field_check("norm_y", e[82:66], got[82:66]);
    field_check("changed", e[83], got[83]);
    field_check("exit_chord", e[84], got[84]);
  endfunction
endclass

module testbench import mtsp_pkg::*; ();

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // event_type, event_code, event_value, pad
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [87:0] m_axis_tdata;  // touch_down, screen_x, screen_y, norm_x, norm_y,
                              // changed, exit_chord, pad
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  touch_scoreboard sb = new();
  int send_idle = 29;
  int recv_idle = 54;
  int quiet = 0;

  multitouch_event_to_screen_point_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_event(s_axis_tdata[4:0], s_axis_tdata[14:5], s_axis_tdata[46:15]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task send_event(logic [4:0] kind, logic [9:0] code, logic [31:0] value);
    if ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      s_axis_tvalid <= 0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, value, code, kind};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task settle();
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task setup(int lx, int hx, int ly, int hy, int w, int h, int mapping, int mode);
    write_reg(REG_MIN_X, lx);
    write_reg(REG_MAX_X, hx);
    write_reg(REG_MIN_Y, ly);
    write_reg(REG_MAX_Y, hy);
    write_reg(REG_SCR_W, w);
    write_reg(REG_SCR_H, h);
    write_reg(REG_MAP, mapping);
    write_reg(REG_MT, mode);
  endtask

  function logic [31:0] coord(longint lo, longint hi);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'(lo);
      2: return 32'(hi);
      default: return 32'(lo + longint'($urandom()) % (hi - lo + 1 > 0 ? hi - lo + 1 : 1));
    endcase
  endfunction

  task random_frame(output int count);
    int n;
    n = $urandom_range(1, 5);
    count = n + 1;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(15))
        0: send_event(5'($urandom()), 10'($urandom()), $urandom());
        1: send_event(EV_KEY, $urandom_range(1) ? CODE_VOL_UP : CODE_VOL_DOWN,
                      $urandom_range(2) == 0 ? $urandom() : $urandom_range(1));
        2: send_event(EV_ABS, CODE_SLOT_SEL, $urandom_range(3) == 0 ? $urandom()
                      : $urandom_range(SLOTS + 2));
        3, 4: send_event(EV_ABS, CODE_TRACK_ID, $urandom_range(1) ? -1
                         : ($urandom_range(3) == 0 ? $urandom() : $urandom_range(500)));
        5: send_event(EV_KEY, CODE_TOUCH_BTN, $urandom_range(2) == 0 ? $urandom()
                      : $urandom_range(1));
        6: send_event(EV_ABS, ABS_X, coord(sb.lo_x, sb.hi_x));
        7: send_event(EV_ABS, ABS_Y, coord(sb.lo_y, sb.hi_y));
        8, 9, 10: send_event(EV_ABS, CODE_MT_X, coord(sb.lo_x, sb.hi_x));
        11, 12, 13: send_event(EV_ABS, CODE_MT_Y, coord(sb.lo_y, sb.hi_y));
        14: send_event(EV_SYN, 10'($urandom()), $urandom());
        default: send_event(EV_ABS, 10'($urandom_range(63)), $urandom());
      endcase
    end
    send_event(EV_SYN, 10'd0, $urandom());
  endtask

  initial begin
    int sent;
    int frames;
    int cnt;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // registers at reset: range not positive, nothing down
    send_event(EV_SYN, 10'd0, 0);
    settle();
    setup(0, 4095, 0, 4095, 1080, 1920, 0, 1);
    send_event(EV_ABS, CODE_TRACK_ID, 5);
    send_event(EV_ABS, CODE_MT_X, 0);
    send_event(EV_ABS, CODE_MT_Y, 4095);
    send_event(EV_SYN, 10'd0, 0);
    send_event(EV_ABS, CODE_SLOT_SEL, 20);
    send_event(EV_ABS, CODE_TRACK_ID, 32'h7fffffff);
    send_event(EV_ABS, CODE_MT_X, 32'h7fffffff);
    send_event(EV_ABS, CODE_MT_Y, 32'h80000000);
    send_event(EV_KEY, CODE_VOL_UP, 1);
    send_event(EV_KEY, CODE_VOL_DOWN, -1);
    send_event(EV_SYN, 10'd0, 0);
    send_event(EV_SYN, 10'd0, 0);
    send_event(EV_ABS, CODE_SLOT_SEL, -3);
    send_event(EV_ABS, CODE_TRACK_ID, -1);
    send_event(EV_KEY, CODE_TOUCH_BTN, 1);
    send_event(EV_ABS, ABS_X, 100);
    send_event(EV_ABS, CODE_SLOT_SEL, SLOTS - 1);
    send_event(EV_ABS, CODE_TRACK_ID, -1);
    send_event(EV_SYN, 10'd0, 0);
    send_event(EV_SYN, 10'd0, 0);
    send_event(5'd7, 10'h3ff, 32'hffffffff);
    send_event(EV_SYN, 10'd5, 0);
    send_event(EV_KEY, CODE_VOL_UP, 0);
    send_event(EV_SYN, 10'd0, 0);
    settle();

    sent = 0;
    frames = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: setup(0, 4095, 0, 4095, 1080, 1920, 0, 1);
        1: setup(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 65535, 65535, 31, 1);
        2: setup(100, 100, -50, 2000, 800, 600, $urandom_range(31), 1);
        3: setup(-1000, 1000, 0, 300, $urandom_range(1, 65535), 1, $urandom_range(31), 0);
        4: setup(32'h7fffffff, 32'h80000000, 0, 1, 1, 1, 0, 0);
        default: setup(-$urandom_range(9999), $urandom_range(1, 9999), 0,
                       $urandom_range(1, 99999), $urandom_range(1, 4000),
                       $urandom_range(1, 4000), $urandom_range(31), 1);
      endcase
      while (sent < (ph + 1) * 150) begin
        if (sent < 300) begin
          send_idle = 29; recv_idle = 54;
        end else if (sent < 600) begin
          send_idle = 54; recv_idle = 29;
        end else begin
          send_idle = 0; recv_idle = 0;
        end
        random_frame(cnt);
        sent += cnt;
        frames++;
        if (frames % 10 == 0) settle();
      end
      settle();
    end

    $display("covered %0d events, %0d reports (%0d changed, %0d with exit chord)",
             sb.events, sb.reports, sb.changes, sb.chords);
    $display("six register settings, both panel modes, all map bits");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
